@@ src/tgcd_pkg.sv @@
// Shared types and constants for the tile geometry command decoder.
`default_nettype none

package tgcd_pkg;

	typedef enum logic [2:0] {
		OP_MOVE  = 3'd0,
		OP_LINE  = 3'd1,
		OP_CLOSE = 3'd2,
		OP_ERROR = 3'd3,
		OP_END   = 3'd4
	} op_t;

	localparam logic [2:0] CMD_MOVE_TO    = 3'd1;
	localparam logic [2:0] CMD_LINE_TO    = 3'd2;
	localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;
	localparam logic [2:0] CMD_NONE       = 3'd0;

	localparam logic [3:0] VARINT_LAST_BYTE = 4'd9;

	function automatic logic [31:0] unzigzag(input logic [31:0] v);
		unzigzag = {1'b0, v[31:1]} ^ {32{v[0]}};
	endfunction

endpackage

`default_nettype wire

@@ src/tgcd_if.sv @@
// Valid/ready channels for geometry bytes and decoded command requests.
`default_nettype none

interface tgcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       field_end;

	modport source(output valid, output data_byte, output field_end, input ready);
	modport sink(input valid, input data_byte, input field_end, output ready);
endinterface

interface tgcd_result_if;
	logic                valid;
	logic                ready;
	tgcd_pkg::op_t       op;
	logic signed [31:0]  cursor_x;
	logic signed [31:0]  cursor_y;
	logic                count_warning;
	logic                last;

	modport source(output valid, output op, output cursor_x, output cursor_y,
		output count_warning, output last, input ready);
	modport sink(input valid, input op, input cursor_x, input cursor_y,
		input count_warning, input last, output ready);
endinterface

`default_nettype wire

@@ src/tile_geometry_command_decoder.sv @@
// Decoder of vector-tile geometry command bytes into cursor point requests.
//
//   channel  | dir | payload                                        | handshake
//   geom     | in  | data_byte[7:0], field_end                      | valid/ready
//   result   | out | op[2:0], cursor_x, cursor_y, count_warning, last | valid/ready
//
// A byte is taken every cycle unless stalled; requests leave the result register.
// The byte register feeds the varint and command logic, which writes the
// result register and the decoder state in the same cycle.
// The byte register stalls only while the result register is full and not taken.
// Reset clears all decoder state, the cursor and both valid flags.
`default_nettype none

module tile_geometry_command_decoder (
	input  wire                   clk,
	input  wire                   arst_n,
	tgcd_byte_if.sink             geom,
	tgcd_result_if.source         result
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;

	logic [31:0] varint_acc_q;
	logic [3:0]  varint_bytes_q;
	logic [2:0]  pending_cmd_q;
	logic [28:0] pairs_left_q;
	logic        have_x_q;
	logic [31:0] delta_x_hold_q;
	logic [31:0] pos_x_q;
	logic [31:0] pos_y_q;
	logic        skipping_q;
	logic        warn_flag_q;

	logic        out_valid_q;
	tgcd_pkg::op_t op_q;
	logic [31:0] cursor_x_q;
	logic [31:0] cursor_y_q;
	logic        warn_q;
	logic        last_q;

	logic        advance;
	logic        more;
	logic [31:0] shifted;
	logic [31:0] acc_or;
	logic [2:0]  cmd_id;
	logic [28:0] cmd_cnt;

	logic [31:0] acc_n;
	logic [3:0]  bytes_n;
	logic [2:0]  pending_n;
	logic [28:0] pairs_n;
	logic        have_x_n;
	logic [31:0] delta_n;
	logic [31:0] pos_x_n;
	logic [31:0] pos_y_n;
	logic        skipping_n;
	logic        warn_n;
	logic        emit;
	tgcd_pkg::op_t op_n;
	logic        cw_n;

	assign advance     = valid_s1 && (!out_valid_q || result.ready);
	assign geom.ready  = !valid_s1 || advance;

	assign more    = byte_s1[7];
	assign cmd_id  = acc_or[2:0];
	assign cmd_cnt = acc_or[31:3];

	always_comb begin
		case (varint_bytes_q)
			4'd0:    shifted = 32'(byte_s1[6:0]);
			4'd1:    shifted = 32'(byte_s1[6:0]) << 7;
			4'd2:    shifted = 32'(byte_s1[6:0]) << 14;
			4'd3:    shifted = 32'(byte_s1[6:0]) << 21;
			4'd4:    shifted = 32'(byte_s1[6:0]) << 28;
			default: shifted = '0;
		endcase
		acc_or = varint_acc_q | shifted;
	end

	always_comb begin
		acc_n      = varint_acc_q;
		bytes_n    = varint_bytes_q;
		pending_n  = pending_cmd_q;
		pairs_n    = pairs_left_q;
		have_x_n   = have_x_q;
		delta_n    = delta_x_hold_q;
		pos_x_n    = pos_x_q;
		pos_y_n    = pos_y_q;
		skipping_n = skipping_q;
		warn_n     = warn_flag_q;
		emit       = 1'b0;
		op_n       = tgcd_pkg::OP_END;
		cw_n       = 1'b0;

		if (!skipping_q) begin
			if (more) begin
				if (varint_bytes_q >= tgcd_pkg::VARINT_LAST_BYTE) begin
					op_n       = tgcd_pkg::OP_ERROR;
					emit       = 1'b1;
					skipping_n = 1'b1;
					acc_n      = '0;
					bytes_n    = '0;
				end else begin
					acc_n   = acc_or;
					bytes_n = varint_bytes_q + 4'd1;
				end
			end else begin
				acc_n   = '0;
				bytes_n = '0;
				if (pending_cmd_q == tgcd_pkg::CMD_NONE) begin
					if (cmd_id == tgcd_pkg::CMD_MOVE_TO ||
							cmd_id == tgcd_pkg::CMD_LINE_TO) begin
						if (cmd_cnt != '0) begin
							pending_n = cmd_id;
							pairs_n   = cmd_cnt;
							have_x_n  = 1'b0;
							warn_n    = (cmd_id == tgcd_pkg::CMD_MOVE_TO) &&
								(cmd_cnt != 29'd1);
						end
					end else if (cmd_id == tgcd_pkg::CMD_CLOSE_PATH) begin
						op_n = tgcd_pkg::OP_CLOSE;
						emit = 1'b1;
						cw_n = (cmd_cnt != 29'd1);
					end else begin
						op_n       = tgcd_pkg::OP_ERROR;
						emit       = 1'b1;
						skipping_n = 1'b1;
					end
				end else if (!have_x_q) begin
					delta_n  = tgcd_pkg::unzigzag(acc_or);
					have_x_n = 1'b1;
				end else begin
					pos_x_n  = pos_x_q + delta_x_hold_q;
					pos_y_n  = pos_y_q + tgcd_pkg::unzigzag(acc_or);
					have_x_n = 1'b0;
					pairs_n  = pairs_left_q - 29'd1;
					op_n     = (pending_cmd_q == tgcd_pkg::CMD_MOVE_TO) ?
						tgcd_pkg::OP_MOVE : tgcd_pkg::OP_LINE;
					cw_n     = warn_flag_q;
					emit     = 1'b1;
					if (pairs_n == '0) begin
						pending_n = tgcd_pkg::CMD_NONE;
						warn_n    = 1'b0;
					end
				end
			end
			if (end_s1 && (more || have_x_n || pending_n != tgcd_pkg::CMD_NONE)) begin
				op_n = tgcd_pkg::OP_ERROR;
				cw_n = 1'b0;
				emit = 1'b1;
			end
		end
		if (!emit) begin
			op_n = tgcd_pkg::OP_END;
			cw_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (geom.valid && geom.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (geom.valid && geom.ready) begin
			byte_s1 <= geom.data_byte;
			end_s1  <= geom.field_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			varint_acc_q   <= '0;
			varint_bytes_q <= '0;
			pending_cmd_q  <= tgcd_pkg::CMD_NONE;
			pairs_left_q   <= '0;
			have_x_q       <= 1'b0;
			delta_x_hold_q <= '0;
			pos_x_q        <= '0;
			pos_y_q        <= '0;
			skipping_q     <= 1'b0;
			warn_flag_q    <= 1'b0;
		end else if (advance) begin
			if (end_s1) begin
				varint_acc_q   <= '0;
				varint_bytes_q <= '0;
				pending_cmd_q  <= tgcd_pkg::CMD_NONE;
				pairs_left_q   <= '0;
				have_x_q       <= 1'b0;
				delta_x_hold_q <= '0;
				pos_x_q        <= '0;
				pos_y_q        <= '0;
				skipping_q     <= 1'b0;
				warn_flag_q    <= 1'b0;
			end else begin
				varint_acc_q   <= acc_n;
				varint_bytes_q <= bytes_n;
				pending_cmd_q  <= pending_n;
				pairs_left_q   <= pairs_n;
				have_x_q       <= have_x_n;
				delta_x_hold_q <= delta_n;
				pos_x_q        <= pos_x_n;
				pos_y_q        <= pos_y_n;
				skipping_q     <= skipping_n;
				warn_flag_q    <= warn_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit || end_s1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_q       <= op_n;
			cursor_x_q <= pos_x_n;
			cursor_y_q <= pos_y_n;
			warn_q     <= cw_n;
			last_q     <= end_s1;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.op            = op_q;
	assign result.cursor_x      = $signed(cursor_x_q);
	assign result.cursor_y      = $signed(cursor_y_q);
	assign result.count_warning = warn_q;
	assign result.last          = last_q;

endmodule

`default_nettype wire

@@ src/tgcd_checker.sv @@
// Port-level checks for the tile geometry command decoder and their binding.
`default_nettype none

module tgcd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire [2:0]  op,
	input wire        count_warning,
	input wire        last
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result request dropped while stalled");

	a_op_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> op <= tgcd_pkg::OP_END)
		else $error("result op code out of range");

	a_warn_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && count_warning |->
			op == tgcd_pkg::OP_MOVE || op == tgcd_pkg::OP_CLOSE)
		else $error("count warning on a request that cannot carry it");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && op == tgcd_pkg::OP_END |-> last)
		else $error("end request without last");

endmodule

bind tile_geometry_command_decoder tgcd_checker u_tgcd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.op            (result.op),
	.count_warning (result.count_warning),
	.last          (result.last)
);

`default_nettype wire

@@ sim/tile_geometry_command_decoder_test.sv @@
// Self-checking testbench for the tile geometry command decoder.
module tile_geometry_command_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int STREAM_BYTES = 776;

	typedef struct {
		tgcd_pkg::op_t op;
		logic [31:0]   x;
		logic [31:0]   y;
		logic          warn;
		logic          last;
	} point_req_t;

	typedef struct {
		logic [7:0] b;
		logic       e;
	} raw_byte_t;

	class cursor_tracker;
		logic [31:0] acc;
		logic [3:0]  nbytes;
		logic [2:0]  cmd;
		logic [28:0] pairs;
		bit          have_x;
		logic [31:0] dx;
		logic [31:0] px;
		logic [31:0] py;
		bit          skip;
		bit          warn;
		point_req_t  owed[$];
		int          fails;

		function new();
			clear();
			fails = 0;
		endfunction

		function void clear();
			acc = '0;
			nbytes = '0;
			cmd = tgcd_pkg::CMD_NONE;
			pairs = '0;
			have_x = 0;
			dx = '0;
			px = '0;
			py = '0;
			skip = 0;
			warn = 0;
		endfunction

		function logic [31:0] zz_decode(input logic [31:0] v);
			return (v >> 1) ^ {32{v[0]}};
		endfunction

		function void note_byte(input logic [7:0] b, input logic e);
			logic [31:0]   v;
			logic [2:0]    id;
			logic [28:0]   cnt;
			bit            more;
			bit            emit;
			bit            cw;
			tgcd_pkg::op_t op;
			point_req_t    r;
			more = 0;
			emit = 0;
			cw = 0;
			op = tgcd_pkg::OP_END;
			if (skip && !e)
				return;
			if (!skip) begin
				more = b[7];
				if (nbytes < 4'd5)
					acc = acc | (32'(b[6:0]) << (7 * nbytes));
				if (more) begin
					if (nbytes >= tgcd_pkg::VARINT_LAST_BYTE) begin
						op = tgcd_pkg::OP_ERROR;
						emit = 1;
						skip = 1;
						acc = '0;
						nbytes = '0;
					end else begin
						nbytes++;
					end
				end else begin
					v = acc;
					acc = '0;
					nbytes = '0;
					if (cmd == tgcd_pkg::CMD_NONE) begin
						id = v[2:0];
						cnt = v[31:3];
						if (id == tgcd_pkg::CMD_MOVE_TO ||
								id == tgcd_pkg::CMD_LINE_TO) begin
							if (cnt != 0) begin
								cmd = id;
								pairs = cnt;
								have_x = 0;
								warn = (id == tgcd_pkg::CMD_MOVE_TO) && (cnt != 1);
							end
						end else if (id == tgcd_pkg::CMD_CLOSE_PATH) begin
							op = tgcd_pkg::OP_CLOSE;
							emit = 1;
							cw = (cnt != 1);
						end else begin
							op = tgcd_pkg::OP_ERROR;
							emit = 1;
							skip = 1;
						end
					end else if (!have_x) begin
						dx = zz_decode(v);
						have_x = 1;
					end else begin
						px = px + dx;
						py = py + zz_decode(v);
						have_x = 0;
						pairs = pairs - 1'b1;
						op = (cmd == tgcd_pkg::CMD_MOVE_TO) ?
							tgcd_pkg::OP_MOVE : tgcd_pkg::OP_LINE;
						cw = warn;
						emit = 1;
						if (pairs == 0) begin
							cmd = tgcd_pkg::CMD_NONE;
							warn = 0;
						end
					end
				end
				if (e && (more || have_x || cmd != tgcd_pkg::CMD_NONE)) begin
					op = tgcd_pkg::OP_ERROR;
					cw = 0;
					emit = 1;
				end
			end
			if (!emit && !e)
				return;
			r.op = op;
			r.x = px;
			r.y = py;
			r.warn = cw;
			r.last = e;
			owed.push_back(r);
			if (e)
				clear();
		endfunction

		function void check_request(input tgcd_pkg::op_t op, input logic [31:0] x,
				input logic [31:0] y, input logic cw, input logic last);
			point_req_t w;
			if (owed.size() == 0) begin
				$error("unexpected request: op %0d x %0d y %0d", op, $signed(x), $signed(y));
				fails++;
				return;
			end
			w = owed.pop_front();
			if (op !== w.op) begin
				$error("op: expected %0d, actual %0d", w.op, op);
				fails++;
			end
			if (x !== w.x) begin
				$error("cursor_x: expected %0d, actual %0d", $signed(w.x), $signed(x));
				fails++;
			end
			if (y !== w.y) begin
				$error("cursor_y: expected %0d, actual %0d", $signed(w.y), $signed(y));
				fails++;
			end
			if (cw !== w.warn) begin
				$error("count_warning: expected %0d, actual %0d", w.warn, cw);
				fails++;
			end
			if (last !== w.last) begin
				$error("last: expected %0d, actual %0d", w.last, last);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	tgcd_byte_if   geom_ch();
	tgcd_result_if res_ch();

	tile_geometry_command_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.geom   (geom_ch),
		.result (res_ch)
	);

	cursor_tracker tracker = new();
	raw_byte_t     feed[$];
	logic [7:0]    field_bytes[$];
	int            quiet = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic add_varint(input logic [31:0] v, input bit pad_ok);
		int         minb;
		int         nb;
		int         i;
		logic [6:0] chunk;
		minb = 1;
		for (i = 1; i < 5; i++)
			if ((v >> (7 * i)) != 0)
				minb = i + 1;
		nb = (pad_ok && $urandom_range(0, 9) == 0) ? $urandom_range(minb, 10) : minb;
		for (i = 0; i < nb; i++) begin
			if (i < 4)
				chunk = v[7 * i +: 7];
			else if (i == 4)
				chunk = {3'($urandom), v[31:28]};
			else
				chunk = 7'($urandom);
			field_bytes.push_back({(i != nb - 1), chunk});
		end
	endtask

	task automatic add_command(input logic [2:0] id, input logic [28:0] cnt, input bit pad_ok);
		add_varint({cnt, id}, pad_ok);
	endtask

	task automatic add_junk(input int n);
		repeat (n) field_bytes.push_back(8'($urandom));
	endtask

	task automatic commit_field(input int keep);
		raw_byte_t rb;
		for (int i = 0; i < keep; i++) begin
			rb.b = field_bytes[i];
			rb.e = (i == keep - 1);
			feed.push_back(rb);
		end
		field_bytes.delete();
	endtask

	function automatic logic [31:0] rand_delta_code();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 15);
			default: return $urandom_range(0, 400);
		endcase
	endfunction

	task automatic build_directed();
		add_command(tgcd_pkg::CMD_LINE_TO, 29'd1, 0);
		add_varint(32'hFFFF_FFFF, 0);
		add_varint(32'hFFFF_FFFE, 0);
		add_command(tgcd_pkg::CMD_CLOSE_PATH, 29'd0, 0);
		commit_field(field_bytes.size());
		add_command(tgcd_pkg::CMD_MOVE_TO, 29'd1, 0);
		add_varint(32'd2, 0);
		add_varint(32'd1, 0);
		commit_field(field_bytes.size());
		add_command(tgcd_pkg::CMD_NONE, 29'd0, 0);
		field_bytes.push_back(8'hFF);
		field_bytes.push_back(8'h00);
		commit_field(field_bytes.size());
		add_command(tgcd_pkg::CMD_MOVE_TO, 29'd0, 0);
		commit_field(field_bytes.size());
		repeat (10) field_bytes.push_back({1'b1, 7'($urandom)});
		commit_field(field_bytes.size());
	endtask

	task automatic make_field();
		int          ncmd;
		int          kind;
		int          cnt;
		int          cut;
		logic [2:0]  id;
		logic [28:0] big;
		if ($urandom_range(0, 19) == 0) begin
			add_junk($urandom_range(1, 8));
			commit_field(field_bytes.size());
			return;
		end
		ncmd = $urandom_range(1, 5);
		for (int k = 0; k < ncmd; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				cnt = $urandom_range(1, 4);
				add_command(tgcd_pkg::CMD_LINE_TO, cnt[28:0], 1);
				repeat (2 * cnt) add_varint(rand_delta_code(), 1);
			end else if (kind < 65) begin
				cnt = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1;
				add_command(tgcd_pkg::CMD_MOVE_TO, cnt[28:0], 1);
				repeat (2 * cnt) add_varint(rand_delta_code(), 1);
			end else if (kind < 80) begin
				case ($urandom_range(0, 3))
					0: big = 29'd0;
					1: big = 29'($urandom);
					default: big = 29'd1;
				endcase
				add_command(tgcd_pkg::CMD_CLOSE_PATH, big, 1);
			end else if (kind < 86) begin
				add_command($urandom_range(0, 1) ? tgcd_pkg::CMD_MOVE_TO :
					tgcd_pkg::CMD_LINE_TO, 29'd0, 1);
			end else if (kind < 90) begin
				big = 29'($urandom) | 29'd2;
				add_command($urandom_range(0, 1) ? tgcd_pkg::CMD_MOVE_TO :
					tgcd_pkg::CMD_LINE_TO, big, 1);
				add_varint(rand_delta_code(), 1);
				add_varint(rand_delta_code(), 1);
				break;
			end else if (kind < 95) begin
				do
					id = 3'($urandom);
				while (id == tgcd_pkg::CMD_MOVE_TO || id == tgcd_pkg::CMD_LINE_TO ||
					id == tgcd_pkg::CMD_CLOSE_PATH);
				add_command(id, 29'($urandom), 1);
				add_junk($urandom_range(0, 3));
				break;
			end else begin
				repeat (10) field_bytes.push_back({1'b1, 7'($urandom)});
				add_junk($urandom_range(0, 3));
				break;
			end
		end
		cut = field_bytes.size();
		if ($urandom_range(0, 9) == 0 && cut > 1)
			cut = $urandom_range(1, cut - 1);
		commit_field(cut);
	endtask

	task automatic drive_bytes();
		int idx;
		int burst;
		int gap;
		bit took;
		idx = 0;
		while (idx < feed.size()) begin
			burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			for (int n = 0; n < burst && idx < feed.size(); n++) begin
				geom_ch.valid <= 1'b1;
				geom_ch.data_byte <= feed[idx].b;
				geom_ch.field_end <= feed[idx].e;
				do begin
					@(negedge clk);
					took = geom_ch.ready;
					@(posedge clk);
				end while (!took);
				idx++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				geom_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		geom_ch.valid <= 1'b0;
	endtask

	initial begin
		int         mode;
		int         left;
		int         ph;
		logic [7:0] pat;
		mode = 0;
		left = 0;
		ph = 0;
		pat = 8'hFF;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(16, 96);
				pat = 8'($urandom) | 8'h01;
			end
			left--;
			case (mode)
				0: res_ch.ready <= 1'b1;
				1: res_ch.ready <= 1'($urandom_range(0, 1));
				default: res_ch.ready <= pat[ph % 8];
			endcase
			ph++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (geom_ch.valid && geom_ch.ready)
				tracker.note_byte(geom_ch.data_byte, geom_ch.field_end);
			if (res_ch.valid && res_ch.ready)
				tracker.check_request(res_ch.op, res_ch.cursor_x, res_ch.cursor_y,
					res_ch.count_warning, res_ch.last);
			if ((geom_ch.valid && geom_ch.ready) || (res_ch.valid && res_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		geom_ch.valid <= 1'b0;
		geom_ch.data_byte <= '0;
		geom_ch.field_end <= 1'b0;
		build_directed();
		while (feed.size() < STREAM_BYTES)
			make_field();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_bytes();
		while (tracker.owed.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.owed.size() != 0) begin
			$error("%0d expected requests never arrived", tracker.owed.size());
			tracker.fails++;
		end
		if (tracker.fails == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

@@ sim.f @@
src/tgcd_pkg.sv
src/tgcd_if.sv
src/tile_geometry_command_decoder.sv
src/tgcd_checker.sv
sim/tile_geometry_command_decoder_test.sv
